[design/spos_pkg.sv]
// Shared types, constants and helpers for the shuffled play-order sequencer.
// No dependencies; imported by spos_mod and the sequencer core.
package spos_pkg;

  localparam int MaxTracks = 255;
  localparam int TrackW    = 8;
  localparam int OrderDepth = 256;
  localparam int RngW      = 32;
  localparam logic [RngW-1:0] SeedMix = 32'h9E37_79B9;

  // Iterative remainder unit: bits retired per cycle and cycle count.
  localparam int ModBitsPerCycle = 2;
  localparam int ModIters        = RngW / ModBitsPerCycle;
  localparam int ModCntW         = $clog2(ModIters);

  // Request codes
  localparam logic [2:0] ReqBegin  = 3'd0;
  localparam logic [2:0] ReqShOn   = 3'd1;
  localparam logic [2:0] ReqShOff  = 3'd2;
  localparam logic [2:0] ReqEnded  = 3'd3;
  localparam logic [2:0] ReqFailed = 3'd4;
  localparam logic [2:0] ReqNext   = 3'd5;
  localparam logic [2:0] ReqPrev   = 3'd6;

  // Step codes
  localparam logic [2:0] StepMoved    = 3'd0;
  localparam logic [2:0] StepSame     = 3'd1;
  localparam logic [2:0] StepStay     = 3'd2;
  localparam logic [2:0] StepFinished = 3'd3;
  localparam logic [2:0] StepNone     = 3'd4;

  // Repeat modes
  localparam logic [1:0] RepOff  = 2'd0;
  localparam logic [1:0] RepOne  = 2'd1;
  localparam logic [1:0] RepLoop = 2'd2;

  // Configuration register indexes
  localparam logic CfgRepeat = 1'b0;
  localparam logic CfgSingle = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_CUR, S_GOT_CUR, S_FILL, S_SH_HEAD, S_SH_FILL, S_GEN, S_MOD,
    S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB, S_FX_RD, S_FX_CMP, S_RESP, S_OUT
  } state_e;

  // Pending rebuild after the current entry is read
  typedef enum logic [1:0] {OP_SHON, OP_SHOFF, OP_WRAP} op_e;

  // What follows a natural fill
  typedef enum logic {FN_DONE, FN_WRAP} fill_next_e;

  // Swap loop flavor
  typedef enum logic [1:0] {LK_HEAD, LK_WRAP, LK_FIX} loop_kind_e;

  typedef struct packed {
    logic              start;
    logic [RngW-1:0]   dividend;
    logic [TrackW-1:0] divisor;
  } mod_req_t;

  function automatic logic [RngW-1:0] xs_next(input logic [RngW-1:0] x);
    logic [RngW-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  function automatic logic [RngW-1:0] seed_fn(input logic [RngW-1:0] s);
    logic [RngW-1:0] y;
    y = s ^ SeedMix;
    return (y == '0) ? RngW'(1) : y;
  endfunction

endpackage

[design/spos_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module spos_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/spos_mod.sv]
// Iterative remainder unit: 32-bit dividend modulo an 8-bit divisor,
// two bits per cycle. Depends on spos_pkg.
module spos_mod import spos_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mod_req_t          req_i,
  output logic              done_o,
  output logic [TrackW-1:0] rem_o
);

  logic               run_q, done_q;
  logic [ModCntW-1:0] cnt_q;
  logic [RngW-1:0]    dvd_q, dvd_d;
  logic [TrackW-1:0]  div_q, rem_q, rem_d;

  always_comb begin
    logic [TrackW:0] t;
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int k = 0; k < ModBitsPerCycle; k++) begin
      t = {rem_d, dvd_d[RngW-1]};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      rem_d = t[TrackW-1:0];
      dvd_d = dvd_d << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + ModCntW'(1);
      if (cnt_q == ModCntW'(ModIters - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[design/shuffled_play_order_sequencer_core.sv]
// Shuffled play-order sequencer core: play-order table in one RAM, sequencer FSM
// and remainder unit. Depends on spos_pkg, spos_ram and spos_mod.
//
// Usage: raise start with req_type_i, track_count_i, start_position_i and
// seed_i; the word is taken at an edge where busy is low. busy stays high
// until the result, which appears on step_o, position_o and active_o for one
// cycle with done_o high; the receiver cannot stall it. Registers are written
// through cfg_we_i / cfg_idx_i / cfg_data_i (0 repeat mode, 1 single mode),
// and the user must do so only while busy is low; the block does not enforce it.
// A request that only moves the cursor goes through the response and output
// states; the next word can be taken in the cycle after the result.
// A natural fill writes track i + 1 into slot i for every slot below count.
// Every shuffle swap starts the remainder unit, waits on it and then makes
// four RAM accesses on the single read and single write port.
// One request is in work at a time. Reset makes the block inactive with
// shuffle off, both registers zero and the generator at one; the table
// content is undefined and is never read before a begin fills it.
module shuffled_play_order_sequencer_core import spos_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        req_type_i,
  input  logic [TrackW-1:0] track_count_i,
  input  logic [TrackW-1:0] start_position_i,
  input  logic [RngW-1:0]   seed_i,
  output logic              done_o,
  output logic [2:0]        step_o,
  output logic [TrackW-1:0] position_o,
  output logic              active_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [1:0]        cfg_data_i
);

  state_e state_q, state_d;
  logic [1:0]        repeat_q;
  logic              single_q;
  logic [TrackW-1:0] cursor_q, cursor_d, count_q, count_d;
  logic              active_q, active_d, shuffle_q, shuffle_d;
  logic [RngW-1:0]   rng_q, rng_d, seed_q, seed_d;
  op_e               op_q, op_d;
  fill_next_e        fn_q, fn_d;
  loop_kind_e        kind_q, kind_d;
  logic [TrackW-1:0] head_q, head_d, last_q, last_d, cnt_q, cnt_d, n_q, n_d;
  logic [TrackW-1:0] idx_q, idx_d, j_q, j_d, va_q, va_d;
  logic [2:0]        step_q, step_d;

  logic              ram_we;
  logic [TrackW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;
  mod_req_t          mod_req;
  logic              mod_done;
  logic [TrackW-1:0] mod_rem;

  spos_ram #(.Width(TrackW), .Depth(OrderDepth)) u_order (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  spos_mod u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .done_o(mod_done),
    .rem_o (mod_rem)
  );

  always_comb begin
    logic more_left, do_wrap, on;
    logic [RngW-1:0] r;
    state_d   = state_q;
    cursor_d  = cursor_q;
    count_d   = count_q;
    active_d  = active_q;
    shuffle_d = shuffle_q;
    rng_d     = rng_q;
    seed_d    = seed_q;
    op_d      = op_q;
    fn_d      = fn_q;
    kind_d    = kind_q;
    head_d    = head_q;
    last_d    = last_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    idx_d     = idx_q;
    j_d       = j_q;
    va_d      = va_q;
    step_d    = step_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = cnt_q + TrackW'(1);
    ram_raddr = cursor_q;
    mod_req   = '0;
    more_left = ({1'b0, cursor_q} + 9'd1) < {1'b0, count_q};
    do_wrap   = 1'b0;
    on        = (req_type_i == ReqShOn);
    r         = xs_next(rng_q);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          seed_d  = seed_i;
          step_d  = StepNone;
          state_d = S_RESP;
          unique case (req_type_i)
            ReqBegin: begin
              if (track_count_i != '0 && track_count_i <= TrackW'(MaxTracks) &&
                  start_position_i != '0 && start_position_i <= track_count_i) begin
                count_d  = track_count_i;
                active_d = 1'b1;
                if (shuffle_q) begin
                  rng_d    = seed_fn(seed_i);
                  head_d   = start_position_i;
                  cursor_d = '0;
                  state_d  = S_SH_HEAD;
                end else begin
                  cursor_d = start_position_i - TrackW'(1);
                  cnt_d    = '0;
                  fn_d     = FN_DONE;
                  state_d  = S_FILL;
                end
              end
            end
            ReqShOn, ReqShOff: begin
              if (on != shuffle_q) begin
                shuffle_d = on;
                if (active_q) begin
                  op_d    = on ? OP_SHON : OP_SHOFF;
                  state_d = S_RD_CUR;
                end
              end
            end
            ReqEnded, ReqFailed, ReqNext, ReqPrev: begin
              if (!active_q) begin
                step_d = StepFinished;
              end else begin
                step_d = StepMoved;
                unique case (req_type_i)
                  ReqEnded: begin
                    if (single_q) begin
                      if (repeat_q == RepOff) begin
                        active_d = 1'b0;
                        step_d   = StepFinished;
                      end else begin
                        step_d = StepSame;
                      end
                    end else if (repeat_q == RepOne) begin
                      step_d = StepSame;
                    end else if (more_left) begin
                      cursor_d = cursor_q + TrackW'(1);
                    end else if (repeat_q == RepLoop) begin
                      do_wrap = 1'b1;
                    end else begin
                      active_d = 1'b0;
                      step_d   = StepFinished;
                    end
                  end
                  ReqFailed: begin
                    if (single_q) begin
                      active_d = 1'b0;
                      step_d   = StepFinished;
                    end else if (more_left) begin
                      cursor_d = cursor_q + TrackW'(1);
                    end else begin
                      do_wrap = 1'b1;
                    end
                  end
                  ReqNext: begin
                    if (more_left) begin
                      cursor_d = cursor_q + TrackW'(1);
                    end else if (repeat_q != RepOff) begin
                      do_wrap = 1'b1;
                    end else begin
                      step_d = StepStay;
                    end
                  end
                  default: begin
                    if (cursor_q != '0) begin
                      cursor_d = cursor_q - TrackW'(1);
                    end else if (repeat_q != RepOff) begin
                      cursor_d = count_q - TrackW'(1);
                    end else begin
                      step_d = StepSame;
                    end
                  end
                endcase
                if (do_wrap) begin
                  if (shuffle_q) begin
                    op_d    = OP_WRAP;
                    state_d = S_RD_CUR;
                  end else begin
                    cursor_d = '0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_CUR: begin
        state_d = S_GOT_CUR;
      end
      S_GOT_CUR: begin
        cnt_d = '0;
        unique case (op_q)
          OP_SHON: begin
            rng_d    = seed_fn(seed_q);
            head_d   = ram_rdata;
            cursor_d = '0;
            state_d  = S_SH_HEAD;
          end
          OP_SHOFF: begin
            cursor_d = ram_rdata - TrackW'(1);
            fn_d     = FN_DONE;
            state_d  = S_FILL;
          end
          default: begin
            last_d   = ram_rdata;
            rng_d    = seed_fn(seed_q);
            cursor_d = '0;
            fn_d     = FN_WRAP;
            state_d  = S_FILL;
          end
        endcase
      end
      S_FILL: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + TrackW'(1);
        if (cnt_q == count_q - TrackW'(1)) begin
          if (fn_q == FN_WRAP && count_q > TrackW'(1)) begin
            idx_d   = count_q - TrackW'(1);
            kind_d  = LK_WRAP;
            state_d = S_GEN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SH_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = head_q;
        cnt_d     = TrackW'(1);
        n_d       = TrackW'(1);
        state_d   = S_SH_FILL;
      end
      S_SH_FILL: begin
        // cnt_q walks the track numbers, n_q the next free slot
        ram_waddr = n_q;
        ram_wdata = cnt_q;
        if (cnt_q != head_q) begin
          ram_we = 1'b1;
          n_d    = n_q + TrackW'(1);
        end
        cnt_d = cnt_q + TrackW'(1);
        if (cnt_q == count_q) begin
          if (count_q > TrackW'(2)) begin
            idx_d   = count_q - TrackW'(1);
            kind_d  = LK_HEAD;
            state_d = S_GEN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_GEN: begin
        rng_d            = r;
        mod_req.start    = 1'b1;
        mod_req.dividend = r;
        unique case (kind_q)
          LK_HEAD: mod_req.divisor = idx_q;
          LK_WRAP: mod_req.divisor = idx_q + TrackW'(1);
          default: mod_req.divisor = count_q - TrackW'(1);
        endcase
        state_d = S_MOD;
      end
      S_MOD: begin
        if (mod_done) begin
          j_d     = (kind_q == LK_WRAP) ? mod_rem : mod_rem + TrackW'(1);
          state_d = S_SW_RA;
        end
      end
      S_SW_RA: begin
        ram_raddr = idx_q;
        state_d   = S_SW_RB;
      end
      S_SW_RB: begin
        ram_raddr = j_q;
        va_d      = ram_rdata;
        state_d   = S_SW_WA;
      end
      S_SW_WA: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        state_d   = S_SW_WB;
      end
      S_SW_WB: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = va_q;
        idx_d     = idx_q - TrackW'(1);
        unique case (kind_q)
          LK_HEAD: state_d = (idx_q > TrackW'(2)) ? S_GEN : S_RESP;
          LK_WRAP: state_d = (idx_q > TrackW'(1)) ? S_GEN : S_FX_RD;
          default: state_d = S_RESP;
        endcase
      end
      S_FX_RD: begin
        ram_raddr = '0;
        state_d   = S_FX_CMP;
      end
      S_FX_CMP: begin
        // keep the track that just played off the new head
        if (ram_rdata == last_q) begin
          idx_d   = '0;
          kind_d  = LK_FIX;
          state_d = S_GEN;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      repeat_q  <= RepOff;
      single_q  <= 1'b0;
      cursor_q  <= '0;
      count_q   <= '0;
      active_q  <= 1'b0;
      shuffle_q <= 1'b0;
      rng_q     <= RngW'(1);
    end else begin
      state_q   <= state_d;
      cursor_q  <= cursor_d;
      count_q   <= count_d;
      active_q  <= active_d;
      shuffle_q <= shuffle_d;
      rng_q     <= rng_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgRepeat: repeat_q <= cfg_data_i;
          default:   single_q <= cfg_data_i[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q <= seed_d;
    op_q   <= op_d;
    fn_q   <= fn_d;
    kind_q <= kind_d;
    head_q <= head_d;
    last_q <= last_d;
    cnt_q  <= cnt_d;
    n_q    <= n_d;
    idx_q  <= idx_d;
    j_q    <= j_d;
    va_q   <= va_d;
    step_q <= step_d;
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = (state_q == S_OUT);
  assign step_o     = step_q;
  assign active_o   = active_q;
  assign position_o = active_q ? ram_rdata : '0;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result word");

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && active_o |-> position_o != '0) else $error("active with empty position");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && !busy |-> cursor_q < count_q) else $error("cursor past count");

  a_mod_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == S_MOD) else $error("remainder done outside wait");

endmodule
